/* design/aeskx_pkg.sv */
// aeskx_pkg: types and constants shared by the aes-256 key expansion unit
// holds the key and round key transaction structs, the s-box and round constant helper
// no dependencies

package aeskx_pkg;

	localparam int unsigned NumRounds = 15;
	localparam logic [3:0] LastRound = 4'(NumRounds - 1);

	typedef struct packed {
		logic [63:0] key_word_0;
		logic [63:0] key_word_1;
		logic [63:0] key_word_2;
		logic [63:0] key_word_3;
	} key_t;

	typedef struct packed {
		logic [3:0]  round_index;
		logic [63:0] round_key_hi;
		logic [63:0] round_key_lo;
		logic        last;
	} round_key_t;

	localparam logic [7:0] SBOX [0:255] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RconBase = 8'h01;

	// round constant for the words generated while round key r is emitted (r even)
	function automatic logic [7:0] rcon(input logic [3:0] round);
		return RconBase << round[3:1];
	endfunction

endpackage

/* design/aes256_key_expansion_unit.sv */
// aes256_key_expansion_unit: top level of the aes-256 key schedule
// depends on aeskx_pkg and aeskx_next_words

// A key is taken with start while busy is low. The unit then presents the 15 round keys,
// round 0 first, one per cycle on round_key with round_valid high, after the key has passed
// through window_q and round_key_q; round 14 carries last. The receiver cannot stall, so
// each round key is there for exactly one cycle. Each key occupies the unit while the schedule
// step derives four new words (four s-box lookups) per cycle; busy drops in the cycle the
// final round key is generated, so a new key may be taken then and its round keys follow
// the previous ones without a gap.

module aes256_key_expansion_unit import aeskx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  key_t       key,
	output logic       round_valid,
	output round_key_t round_key
);

	logic [255:0] window_q;
	logic [255:0] window_next;
	logic [3:0]   round_q;
	logic         active_q;
	logic         accept;
	logic         final_round;
	round_key_t   round_key_q;
	logic         round_valid_q;

	assign final_round = (round_q == LastRound);
	assign busy        = active_q && !final_round;
	assign accept      = start && !busy;

	aeskx_next_words u_next (
		.window      (window_q),
		.round       (round_q),
		.window_next (window_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			round_q       <= '0;
			round_valid_q <= 1'b0;
		end else begin
			round_valid_q <= active_q;
			if (accept) begin
				active_q <= 1'b1;
				round_q  <= '0;
			end else if (active_q) begin
				active_q <= !final_round;
				round_q  <= final_round ? '0 : round_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			window_q <= {key.key_word_0, key.key_word_1, key.key_word_2, key.key_word_3};
		end else if (active_q) begin
			window_q <= window_next;
		end
		if (active_q) begin
			round_key_q.round_index  <= round_q;
			round_key_q.round_key_hi <= window_q[255:192];
			round_key_q.round_key_lo <= window_q[191:128];
			round_key_q.last         <= final_round;
		end
	end

	assign round_valid = round_valid_q;
	assign round_key   = round_key_q;

	a_first_round: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 (round_valid && round_key.round_index == '0))
		else $error("round 0 not emitted two cycles after key accept");

	a_rounds_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		(round_valid && !round_key.last) |=>
			(round_valid && round_key.round_index == $past(round_key.round_index) + 4'd1))
		else $error("round keys not contiguous");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(round_valid && round_key.last) |-> (round_key.round_index == LastRound))
		else $error("last flag on wrong round");

	a_busy_active: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> round_valid)
		else $error("busy without round key output");

endmodule

/* design/aeskx_sub_word.sv */
// aeskx_sub_word: applies the aes s-box to each byte of a 32-bit word
// depends on aeskx_pkg for the s-box table

module aeskx_sub_word import aeskx_pkg::*; (
	input  logic [31:0] word,
	output logic [31:0] subbed
);

	assign subbed = {SBOX[word[31:24]], SBOX[word[23:16]], SBOX[word[15:8]], SBOX[word[7:0]]};

endmodule

/* design/aeskx_next_words.sv */
// aeskx_next_words: one step of the aes-256 schedule, builds the next four words
// from an eight-word window; depends on aeskx_pkg and aeskx_sub_word

module aeskx_next_words import aeskx_pkg::*; (
	input  logic [255:0] window,
	input  logic [3:0]   round,
	output logic [255:0] window_next
);

	logic [31:0] w0, w1, w2, w3, w7;
	logic [31:0] sub_in, sub_out, mix;
	logic [31:0] n0, n1, n2, n3;

	assign w0 = window[255:224];
	assign w1 = window[223:192];
	assign w2 = window[191:160];
	assign w3 = window[159:128];
	assign w7 = window[31:0];

	// even round: new words start at a multiple of eight, so rotate and add rcon
	assign sub_in = round[0] ? w7 : {w7[23:0], w7[31:24]};

	aeskx_sub_word u_sub (
		.word   (sub_in),
		.subbed (sub_out)
	);

	assign mix = round[0] ? sub_out : (sub_out ^ {rcon(round), 24'h0});

	assign n0 = w0 ^ mix;
	assign n1 = w1 ^ n0;
	assign n2 = w2 ^ n1;
	assign n3 = w3 ^ n2;

	assign window_next = {window[127:0], n0, n1, n2, n3};

endmodule

/* dv/aeskx_round_key_checker.sv */
// aeskx_round_key_checker: watches the key and round key channels of the key expansion unit,
// predicts the fifteen round keys of every accepted key and compares them in order
// depends on aeskx_pkg for the key_t and round_key_t transaction types

module aeskx_round_key_checker import aeskx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  key_t       key,
	input  logic       round_valid,
	input  round_key_t round_key,
	output int         pending,
	output int         errors
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MaxReports = 50;

	logic [7:0] sub_byte_tbl [256];
	round_key_t expected_round_keys [$];

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = '0;
		for (int n = 0; n < 8; n++) begin
			if (b[0])
				p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
			b = b >> 1;
		end
		return p;
	endfunction

	// s-box built from the field inverse and the affine map
	initial begin
		logic [7:0] inv;
		for (int x = 0; x < 256; x++) begin
			inv = '0;
			for (int y = 1; y < 256; y++)
				if (gf_mul(8'(x), 8'(y)) == 8'h01)
					inv = 8'(y);
			sub_byte_tbl[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
				{inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
		end
	end

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sub_byte_tbl[w[31:24]], sub_byte_tbl[w[23:16]],
			sub_byte_tbl[w[15:8]], sub_byte_tbl[w[7:0]]};
	endfunction

	function automatic void expand_key(input key_t k);
		logic [31:0] w [60];
		logic [31:0] mix;
		logic [7:0]  rc;
		round_key_t  rk;
		{w[0], w[1]} = k.key_word_0;
		{w[2], w[3]} = k.key_word_1;
		{w[4], w[5]} = k.key_word_2;
		{w[6], w[7]} = k.key_word_3;
		for (int i = 8; i < 60; i++) begin
			mix = w[i - 1];
			if (i % 8 == 0) begin
				rc = 8'h01 << (i / 8 - 1);
				mix = sub_word({mix[23:0], mix[31:24]}) ^ {rc, 24'h0};
			end else if (i % 8 == 4) begin
				mix = sub_word(mix);
			end
			w[i] = w[i - 8] ^ mix;
		end
		for (int r = 0; r < 15; r++) begin
			rk.round_index = 4'(r);
			rk.round_key_hi = {w[4 * r], w[4 * r + 1]};
			rk.round_key_lo = {w[4 * r + 2], w[4 * r + 3]};
			rk.last = (r == 14);
			expected_round_keys.push_back(rk);
		end
	endfunction

	always @(posedge clk) begin
		round_key_t exp_rk;
		if (!arst_n) begin
			pending = 0;
			errors = 0;
		end else begin
			// results go first: a key taken this cycle answers only after the unit's window and round key registers
			if (round_valid) begin
				if (expected_round_keys.size() == 0) begin
					if (errors < MaxReports)
						$display("%0t: round key with none expected: index %0d hi %h lo %h last %b",
							$time, round_key.round_index, round_key.round_key_hi,
							round_key.round_key_lo, round_key.last);
					errors++;
				end else begin
					exp_rk = expected_round_keys.pop_front();
					if (round_key.round_index !== exp_rk.round_index) begin
						if (errors < MaxReports)
							$display("%0t: round_index expected %0d actual %0d", $time,
								exp_rk.round_index, round_key.round_index);
						errors++;
					end
					if (round_key.round_key_hi !== exp_rk.round_key_hi) begin
						if (errors < MaxReports)
							$display("%0t: round %0d round_key_hi expected %h actual %h", $time,
								exp_rk.round_index, exp_rk.round_key_hi, round_key.round_key_hi);
						errors++;
					end
					if (round_key.round_key_lo !== exp_rk.round_key_lo) begin
						if (errors < MaxReports)
							$display("%0t: round %0d round_key_lo expected %h actual %h", $time,
								exp_rk.round_index, exp_rk.round_key_lo, round_key.round_key_lo);
						errors++;
					end
					if (round_key.last !== exp_rk.last) begin
						if (errors < MaxReports)
							$display("%0t: round %0d last expected %b actual %b", $time,
								exp_rk.round_index, exp_rk.last, round_key.last);
						errors++;
					end
				end
			end
			if (start && !busy)
				expand_key(key);
			pending = expected_round_keys.size();
		end
	end

endmodule

/* dv/aes256_key_expansion_unit_tb.sv */
// aes256_key_expansion_unit_tb: drives directed keys and then random bursts of keys into the key expansion unit
// and reports the verdict; depends on aeskx_pkg, the unit and aeskx_round_key_checker

module aes256_key_expansion_unit_tb import aeskx_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RandomKeys  = 220;
	localparam int CycleLimit  = 200000;
	localparam int DrainCycles = 24;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	key_t       key;
	logic       round_valid;
	round_key_t round_key;
	int         pending;
	int         errors;
	int         cycle_count = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	aes256_key_expansion_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.key         (key),
		.round_valid (round_valid),
		.round_key   (round_key)
	);

	aeskx_round_key_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.key         (key),
		.round_valid (round_valid),
		.round_key   (round_key),
		.pending     (pending),
		.errors      (errors)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic key_t random_key();
		key_t k;
		k.key_word_0 = {$urandom, $urandom};
		k.key_word_1 = {$urandom, $urandom};
		k.key_word_2 = {$urandom, $urandom};
		k.key_word_3 = {$urandom, $urandom};
		return k;
	endfunction

	// holds start until the transaction is taken
	task automatic send_key(input key_t k);
		@(negedge clk);
		start <= 1'b1;
		key <= k;
		do @(posedge clk); while (busy);
	endtask

	// idle cycles with noise on the key bus
	task automatic pause(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
			key <= random_key();
		end
	endtask

	initial begin
		key_t directed_keys [$];
		int   sent;
		int   burst;
		arst_n = 1'b0;
		start = 1'b0;
		key = '0;

		directed_keys.push_back('0);
		directed_keys.push_back('1);
		directed_keys.push_back({4{64'hAAAA_AAAA_AAAA_AAAA}});
		directed_keys.push_back({4{64'h5555_5555_5555_5555}});
		directed_keys.push_back(256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f);
		directed_keys.push_back(256'h603deb1015ca71be2b73aef0857d77811f352c073b6108d72d9810a30914dff4);
		for (int i = 0; i < 4; i++) begin
			directed_keys.push_back(key_t'({64'hFFFF_FFFF_FFFF_FFFF, 192'h0} >> (64 * i)));
			directed_keys.push_back(key_t'({64'h8000_0000_0000_0001, 192'h0} >> (64 * i)));
		end
		directed_keys.push_back({8{32'h6363_6363}});

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_keys[i]) begin
			send_key(directed_keys[i]);
			if ($urandom_range(0, 1) == 0)
				pause($urandom_range(1, 20));
		end

		sent = 0;
		while (sent < RandomKeys) begin
			burst = $urandom_range(1, 8);
			repeat (burst) begin
				send_key(random_key());
				sent++;
			end
			// zero gap keeps some bursts running straight into the next
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(1, 40));
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
